[design/pan_tilt_servo_jog_pwm_assert.svh]
// assertion macros for the pan/tilt servo jog block
// expects clk and arst_n in the scope of the module that uses them
`ifndef PAN_TILT_SERVO_JOG_PWM_ASSERT_SVH
`define PAN_TILT_SERVO_JOG_PWM_ASSERT_SVH

// antecedent holds in a cycle, consequent holds in the same cycle
`define PTSJ_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent holds in a cycle, consequent holds in the next one
`define PTSJ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/ptsj_pkg.sv]
// shared types and constants for the pan/tilt servo jog block
// no dependencies
`timescale 1ns / 1ps

package ptsj_pkg;

	localparam int POS_BITS = 10;
	localparam int REG_W    = 10;
	localparam int FRAME_W  = 11;
	localparam int CMP_W    = (POS_BITS > FRAME_W) ? POS_BITS : FRAME_W;
	localparam int CMD_W    = 8;
	localparam int IDX_W    = 3;

	typedef enum logic [IDX_W-1:0] {
		REG_TILT_MIN = 3'd0,
		REG_TILT_MAX = 3'd1,
		REG_PAN_MIN  = 3'd2,
		REG_PAN_MAX  = 3'd3,
		REG_BASE     = 3'd4,
		REG_WINDOW   = 3'd5
	} cfg_reg_t;

	localparam logic [REG_W-1:0] RST_TILT_MIN = REG_W'(191);
	localparam logic [REG_W-1:0] RST_TILT_MAX = REG_W'(400);
	localparam logic [REG_W-1:0] RST_PAN_MIN  = REG_W'(191);
	localparam logic [REG_W-1:0] RST_PAN_MAX  = REG_W'(430);
	localparam logic [REG_W-1:0] RST_BASE     = REG_W'(440);
	localparam logic [REG_W-1:0] RST_WINDOW   = REG_W'(430);

	localparam logic [POS_BITS-1:0] RST_TILT_POS = POS_BITS'(296);
	localparam logic [POS_BITS-1:0] RST_PAN_POS  = POS_BITS'(310);

	// command byte layout
	localparam int LED_BIT = 3;
	localparam int TILT_LO = 4;
	localparam int PAN_LO  = 6;
	localparam logic [1:0] STEP_UP = 2'b11;
	localparam logic [1:0] STEP_DN = 2'b10;

	localparam logic ACT_CMD  = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	// per-axis controls for one processed beat
	typedef struct packed {
		logic cmd;      // command beat
		logic step_up;
		logic step_dn;
		logic start;    // frame starts with pulses high
		logic tick;     // tick beat while a frame runs
		logic win;      // tick falls inside the countdown window
		logic stop;     // frame ends on this tick
	} axis_ctl_t;

endpackage

[design/pan_tilt_servo_jog_pwm.sv]
// path: an accepted beat is held in the input stage, then registered into the result register that drives out_valid
// throughput: one beat per cycle while out_ready keeps the result moving, set by the state update after the input stage
// while a result waits the input stage takes one more beat, then in_ready drops until out_ready
// reset: positions go to center, led off, frame idle, limit and timing registers to defaults
// depends on ptsj_pkg, ptsj_axis and pan_tilt_servo_jog_pwm_assert.svh
`timescale 1ns / 1ps
`include "pan_tilt_servo_jog_pwm_assert.svh"

module pan_tilt_servo_jog_pwm (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            action,
	input  logic [ptsj_pkg::CMD_W-1:0]      command_byte,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            pan_pulse,
	output logic                            tilt_pulse,
	output logic                            led_level,
	output logic [ptsj_pkg::REG_W-1:0]      pan_position,
	output logic [ptsj_pkg::REG_W-1:0]      tilt_position,
	output logic                            pan_blocked,
	output logic                            tilt_blocked,
	output logic                            frame_active,
	input  logic                            cfg_we,
	input  logic [ptsj_pkg::IDX_W-1:0]      cfg_index,
	input  logic [ptsj_pkg::REG_W-1:0]      cfg_data
);

	// configuration registers
	logic [ptsj_pkg::REG_W-1:0] tilt_min_q, tilt_max_q, pan_min_q, pan_max_q;
	logic [ptsj_pkg::REG_W-1:0] base_q, window_q;

	// input stage
	logic                        valid_s1;
	logic                        action_s1;
	logic [ptsj_pkg::CMD_W-1:0]  cmd_s1;

	// frame state
	logic                          led_q;
	logic                          running_q;
	logic [ptsj_pkg::FRAME_W-1:0]  tick_q;

	// result register
	logic                           out_valid_q;
	logic                           pan_pulse_q, tilt_pulse_q, led_out_q;
	logic [ptsj_pkg::REG_W-1:0]     pan_pos_q, tilt_pos_q;
	logic                           pan_blk_q, tilt_blk_q, active_q;

	logic                          advance;
	logic                          fire;
	logic                          is_cmd;
	logic                          is_tick;
	logic [ptsj_pkg::FRAME_W-1:0]  total;
	logic [ptsj_pkg::FRAME_W-1:0]  tick_next;
	logic [ptsj_pkg::FRAME_W-1:0]  count;
	logic                          in_win;
	logic                          stop;
	logic                          led_d;
	logic                          running_d;
	logic [ptsj_pkg::FRAME_W-1:0]  tick_d;
	logic [1:0]                    tilt_op, pan_op;

	ptsj_pkg::axis_ctl_t           tilt_ctl, pan_ctl;
	logic [ptsj_pkg::POS_BITS-1:0] tilt_now, pan_now, tilt_pos_d, pan_pos_d;
	logic                          tilt_high_d, pan_high_d, tilt_blk, pan_blk;

	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign fire     = valid_s1 && advance;
	assign is_cmd   = fire && (action_s1 == ptsj_pkg::ACT_CMD);
	assign is_tick  = fire && (action_s1 == ptsj_pkg::ACT_TICK) && running_q;

	assign total     = ptsj_pkg::FRAME_W'(base_q) + ptsj_pkg::FRAME_W'(window_q);
	assign tick_next = tick_q + 1'b1;
	// countdown value window-1-(k-base), which equals total-1-k inside the window
	assign count     = total - 1'b1 - tick_q;
	assign in_win    = (tick_q >= ptsj_pkg::FRAME_W'(base_q)) && (tick_q < total);
	assign stop      = tick_next >= total;

	assign tilt_op = cmd_s1[ptsj_pkg::TILT_LO +: 2];
	assign pan_op  = cmd_s1[ptsj_pkg::PAN_LO +: 2];

	always_comb begin
		tilt_ctl.cmd     = is_cmd;
		tilt_ctl.step_up = tilt_op == ptsj_pkg::STEP_UP;
		tilt_ctl.step_dn = tilt_op == ptsj_pkg::STEP_DN;
		tilt_ctl.start   = total != '0;
		tilt_ctl.tick    = is_tick;
		tilt_ctl.win     = in_win;
		tilt_ctl.stop    = stop;
		pan_ctl          = tilt_ctl;
		pan_ctl.step_up  = pan_op == ptsj_pkg::STEP_UP;
		pan_ctl.step_dn  = pan_op == ptsj_pkg::STEP_DN;
	end

	ptsj_axis u_tilt (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (tilt_ctl),
		.lo      (tilt_min_q),
		.hi      (tilt_max_q),
		.rst_pos (ptsj_pkg::RST_TILT_POS),
		.count   (count),
		.pos_q   (tilt_now),
		.pos_d   (tilt_pos_d),
		.high_d  (tilt_high_d),
		.blocked (tilt_blk)
	);

	ptsj_axis u_pan (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (pan_ctl),
		.lo      (pan_min_q),
		.hi      (pan_max_q),
		.rst_pos (ptsj_pkg::RST_PAN_POS),
		.count   (count),
		.pos_q   (pan_now),
		.pos_d   (pan_pos_d),
		.high_d  (pan_high_d),
		.blocked (pan_blk)
	);

	always_comb begin
		led_d     = led_q;
		running_d = running_q;
		tick_d    = tick_q;
		if (is_cmd) begin
			led_d     = cmd_s1[ptsj_pkg::LED_BIT];
			running_d = total != '0;
			tick_d    = '0;
		end else if (is_tick) begin
			running_d = !stop;
			tick_d    = stop ? '0 : tick_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tilt_min_q <= ptsj_pkg::RST_TILT_MIN;
			tilt_max_q <= ptsj_pkg::RST_TILT_MAX;
			pan_min_q  <= ptsj_pkg::RST_PAN_MIN;
			pan_max_q  <= ptsj_pkg::RST_PAN_MAX;
			base_q     <= ptsj_pkg::RST_BASE;
			window_q   <= ptsj_pkg::RST_WINDOW;
		end else if (cfg_we) begin
			case (cfg_index)
				ptsj_pkg::REG_TILT_MIN: tilt_min_q <= cfg_data;
				ptsj_pkg::REG_TILT_MAX: tilt_max_q <= cfg_data;
				ptsj_pkg::REG_PAN_MIN:  pan_min_q  <= cfg_data;
				ptsj_pkg::REG_PAN_MAX:  pan_max_q  <= cfg_data;
				ptsj_pkg::REG_BASE:     base_q     <= cfg_data;
				ptsj_pkg::REG_WINDOW:   window_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			action_s1 <= action;
			cmd_s1    <= command_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_q     <= 1'b0;
			running_q <= 1'b0;
			tick_q    <= '0;
		end else if (fire) begin
			led_q     <= led_d;
			running_q <= running_d;
			tick_q    <= tick_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			pan_pulse_q  <= pan_high_d;
			tilt_pulse_q <= tilt_high_d;
			led_out_q    <= led_d;
			pan_pos_q    <= ptsj_pkg::REG_W'(pan_pos_d);
			tilt_pos_q   <= ptsj_pkg::REG_W'(tilt_pos_d);
			pan_blk_q    <= pan_blk;
			tilt_blk_q   <= tilt_blk;
			active_q     <= running_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign pan_pulse     = pan_pulse_q;
	assign tilt_pulse    = tilt_pulse_q;
	assign led_level     = led_out_q;
	assign pan_position  = pan_pos_q;
	assign tilt_position = tilt_pos_q;
	assign pan_blocked   = pan_blk_q;
	assign tilt_blocked  = tilt_blk_q;
	assign frame_active  = active_q;

	`PTSJ_ASSERT_SAME(a_pulse_needs_frame, out_valid_q && (pan_pulse_q || tilt_pulse_q),
		active_q, "pulse high outside a frame")
	`PTSJ_ASSERT_SAME(a_idle_tick_zero, !running_q, tick_q == '0,
		"frame counter not cleared while idle")
	`PTSJ_ASSERT_NEXT(a_pos_hold, !fire, $stable(pan_now) && $stable(tilt_now),
		"position moved with no beat processed")
	`PTSJ_ASSERT_NEXT(a_cmd_restarts, is_cmd, tick_q == '0,
		"command did not restart the frame")

endmodule

[design/ptsj_axis.sv]
// one servo axis: position register with limited stepping and pulse level
// depends on ptsj_pkg
`timescale 1ns / 1ps

module ptsj_axis (
	input  logic                               clk,
	input  logic                               arst_n,
	input  ptsj_pkg::axis_ctl_t                ctl,
	input  logic [ptsj_pkg::REG_W-1:0]         lo,
	input  logic [ptsj_pkg::REG_W-1:0]         hi,
	input  logic [ptsj_pkg::POS_BITS-1:0]      rst_pos,
	input  logic [ptsj_pkg::FRAME_W-1:0]       count,
	output logic [ptsj_pkg::POS_BITS-1:0]      pos_q,
	output logic [ptsj_pkg::POS_BITS-1:0]      pos_d,
	output logic                               high_d,
	output logic                               blocked
);

	logic high_q;
	logic at_hi;
	logic at_lo;
	logic below_pos;

	assign at_hi     = ptsj_pkg::CMP_W'(pos_q) >= ptsj_pkg::CMP_W'(hi);
	assign at_lo     = ptsj_pkg::CMP_W'(pos_q) <= ptsj_pkg::CMP_W'(lo);
	assign below_pos = ptsj_pkg::CMP_W'(count) <= ptsj_pkg::CMP_W'(pos_q);

	always_comb begin
		pos_d   = pos_q;
		high_d  = high_q;
		blocked = 1'b0;
		if (ctl.cmd) begin
			if (ctl.step_up) begin
				blocked = at_hi;
				if (!at_hi)
					pos_d = pos_q + 1'b1;
			end else if (ctl.step_dn) begin
				blocked = at_lo;
				if (!at_lo)
					pos_d = pos_q - 1'b1;
			end
			high_d = ctl.start;
		end else if (ctl.tick) begin
			if (ctl.win && below_pos)
				high_d = 1'b0;
			if (ctl.stop)
				high_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= rst_pos;
			high_q <= 1'b0;
		end else if (ctl.cmd || ctl.tick) begin
			pos_q  <= pos_d;
			high_q <= high_d;
		end
	end

endmodule
